@@ src/integer_to_ascii_formatter_assert.svh @@
// ----------------------------------------------------------------------------
// Integer to ASCII formatter assertion macros
// Concurrent assertion helpers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

`ifndef SYNTH

// The expression holds at every clock edge outside reset.
`define I2A_ASSERT_HOLDS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("i2a: invariant violated");

// When the antecedent holds, the consequent holds in the same cycle.
`define I2A_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("i2a: implication violated");

// When the antecedent holds, the consequent holds in the next cycle.
`define I2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("i2a: next-cycle check violated");

`else

`define I2A_ASSERT_HOLDS(lbl, clk, rst_n, expr)
`define I2A_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define I2A_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

@@ src/i2a_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Shared widths, mode codes, digit cell operations and character helpers.
// ----------------------------------------------------------------------------
package i2a_pkg;

	// Default number of digit cells in the chain.
	localparam int unsigned DIGIT_SLOTS_DEF = 20;

	// Field widths.
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned VALUE_W = 64;
	localparam int unsigned ROOM_W  = 6;
	localparam int unsigned CH_W    = 7;
	localparam int unsigned DIGIT_W = 4;

	// Packed stream widths.
	localparam int unsigned S_DATA_W = ((VALUE_W + ROOM_W + 7) / 8) * 8;
	localparam int unsigned M_DATA_W = ((CH_W + 7) / 8) * 8;

	// Hex text of a 32-bit word has this many digits.
	localparam int unsigned HEX_DIGITS = 32 / DIGIT_W;

	// Conversion modes.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_U64 = 2'd0,
		FUNC_S32 = 2'd1,
		FUNC_U32 = 2'd2,
		FUNC_HEX = 2'd3
	} func_t;

	// Operations that every digit cell performs in lockstep.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
	} cell_ctrl_t;

	// Characters.
	localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CH_W-1:0] CH_UPPER = 7'h41;
	localparam logic [CH_W-1:0] CH_MINUS = 7'h2d;
	localparam logic [DIGIT_W-1:0] DEC_MAX = 4'd9;

	// Map a digit value to its ASCII character.
	function automatic logic [CH_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CH_W-1:0] wide;
		wide = {{(CH_W-DIGIT_W){1'b0}}, d};
		if (d > DEC_MAX) begin
			return CH_UPPER + wide - (CH_W'(DEC_MAX) + CH_W'(1));
		end
		return CH_ZERO + wide;
	endfunction

endpackage

@@ src/integer_to_ascii_formatter.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII formatter
// Converts one number to ASCII text, most significant character first.
// ----------------------------------------------------------------------------
// One number is handled at a time. A row of DIGIT_SLOTS digit cells does a
// shift-and-add-three conversion two bits per cycle in the decimal modes
// (hex digits are loaded straight in), then shifts its digits out of the top
// cell one per cycle while the output is not stalled. Leading zero cells are
// skipped first, keeping at least one digit, and at most max_chars characters
// are sent, a minus sign counting as one.
// A new number is accepted once the last character is in the output register.
// An item with max_chars of zero is accepted and produces no output.
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter
	import i2a_pkg::*;
#(
	parameter int unsigned DIGIT_SLOTS = DIGIT_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Input stream.
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [S_DATA_W-1:0] s_tdata,  // value [63:0], max_chars [69:64], zeros
	input  logic [FUNC_W-1:0]   s_tuser,  // func [1:0]
	// Output stream.
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,  // ch [6:0], zero [7]
	output logic                m_tlast
);

	localparam int unsigned SLOT_W = $clog2(DIGIT_SLOTS + 1);
	localparam logic [4:0]  ITER_64 = 5'(VALUE_W / 2 - 1);
	localparam logic [4:0]  ITER_32 = 5'(VALUE_W / 4 - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [VALUE_W-1:0]  work_q;
	logic [4:0]          iter_q;
	logic [ROOM_W-1:0]   room_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                neg_q;
	logic                m_tvalid_q;
	logic [CH_W-1:0]     m_ch_q;
	logic                m_tlast_q;

	logic [VALUE_W-1:0]  in_value;
	logic [ROOM_W-1:0]   in_room;
	func_t               in_func;
	logic [31:0]         in_lo;
	logic                in_neg;
	logic [31:0]         in_mag;
	logic                s_accept;
	logic                start;
	logic                out_free;
	logic                emit_go;
	logic                in_tail;
	logic                emit_last;
	logic [DIGIT_W-1:0]  top_digit;
	cell_ctrl_t          cell_ctrl;

	logic [DIGIT_W-1:0]  digit_w [DIGIT_SLOTS];
	logic [1:0]          bits_w  [DIGIT_SLOTS];
	logic [DIGIT_W-1:0]  load_w  [DIGIT_SLOTS];

	// Input unpacking and sign handling.
	assign in_value = s_tdata[VALUE_W-1:0];
	assign in_room  = s_tdata[VALUE_W +: ROOM_W];
	assign in_func  = func_t'(s_tuser);
	assign in_lo    = in_value[31:0];
	assign in_neg   = (in_func == FUNC_S32) && in_lo[31];
	assign in_mag   = in_neg ? (~in_lo + 32'd1) : in_lo;

	assign s_tready = (state_q == ST_IDLE);
	assign s_accept = s_tvalid && s_tready;
	assign start    = s_accept && (in_room != '0);
	assign out_free = !m_tvalid_q || m_tready;
	assign emit_go  = (state_q == ST_EMIT) && out_free;
	assign in_tail  = (state_q == ST_SKIP) || (state_q == ST_EMIT);
	assign top_digit = digit_w[DIGIT_SLOTS-1];

	// The character being sent now is the last when room runs out or digits do.
	assign emit_last = (room_q == ROOM_W'(1)) || (!neg_q && (slot_q == SLOT_W'(1)));

	// Operation for the whole cell row.
	always_comb begin
		cell_ctrl.op = CELL_HOLD;
		if (start) begin
			cell_ctrl.op = CELL_LOAD;
		end else if (state_q == ST_CONV) begin
			cell_ctrl.op = CELL_DABBLE;
		end else if ((state_q == ST_SKIP) && (top_digit == '0) &&
				(slot_q > SLOT_W'(1))) begin
			cell_ctrl.op = CELL_SHIFT;
		end else if (emit_go && !neg_q) begin
			cell_ctrl.op = CELL_SHIFT;
		end
	end

	// Row of digit cells; cell 0 is the least significant digit.
	for (genvar i = 0; i < DIGIT_SLOTS; i++) begin : g_cell
		if (i < HEX_DIGITS) begin : g_hex
			assign load_w[i] = (in_func == FUNC_HEX) ? in_lo[DIGIT_W*i +: DIGIT_W] : '0;
		end else begin : g_zero
			assign load_w[i] = '0;
		end

		if (i == 0) begin : g_first
			i2a_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl),
				.load_digit (load_w[i]),
				.in_bits    (work_q[VALUE_W-1 -: 2]),
				.in_digit   ('0),
				.digit      (digit_w[i]),
				.out_bits   (bits_w[i])
			);
		end else begin : g_rest
			i2a_cell u_cell (
				.clk        (clk),
				.ctrl       (cell_ctrl),
				.load_digit (load_w[i]),
				.in_bits    (bits_w[i-1]),
				.in_digit   (digit_w[i-1]),
				.digit      (digit_w[i]),
				.out_bits   (bits_w[i])
			);
		end
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			work_q     <= '0;
			iter_q     <= '0;
			room_q     <= '0;
			slot_q     <= '0;
			neg_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_ch_q     <= '0;
			m_tlast_q  <= 1'b0;
		end else begin
			// Output valid rises with each loaded character and falls once taken.
			if (emit_go) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						room_q <= in_room;
						neg_q  <= in_neg;
						slot_q <= SLOT_W'(DIGIT_SLOTS);
						if (in_func == FUNC_HEX) begin
							state_q <= ST_SKIP;
						end else if (in_func == FUNC_U64) begin
							state_q <= ST_CONV;
							work_q  <= in_value;
							iter_q  <= ITER_64;
						end else begin
							state_q <= ST_CONV;
							work_q  <= {in_mag, 32'd0};
							iter_q  <= ITER_32;
						end
					end
				end
				ST_CONV: begin
					work_q <= {work_q[VALUE_W-3:0], 2'b00};
					iter_q <= iter_q - 5'd1;
					if (iter_q == '0) begin
						state_q <= ST_SKIP;
					end
				end
				ST_SKIP: begin
					// Drop leading zero digits, keeping at least one.
					if ((top_digit == '0) && (slot_q > SLOT_W'(1))) begin
						slot_q <= slot_q - SLOT_W'(1);
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						m_tlast_q  <= emit_last;
						room_q     <= room_q - ROOM_W'(1);
						if (neg_q) begin
							m_ch_q <= CH_MINUS;
							neg_q  <= 1'b0;
						end else begin
							m_ch_q <= digit_char(top_digit);
							slot_q <= slot_q - SLOT_W'(1);
						end
						if (emit_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(M_DATA_W-CH_W){1'b0}}, m_ch_q};
	assign m_tlast  = m_tlast_q;

	// Room is never exhausted while a number is in progress.
	`I2A_ASSERT_IMPLIES(a_room_live, clk, arst_n, state_q != ST_IDLE, room_q != '0)
	// A digit is always left to send in the skip and emit phases.
	`I2A_ASSERT_IMPLIES(a_slot_live, clk, arst_n, in_tail, slot_q != '0)
	// Decimal conversion keeps every top digit a valid decimal digit.
	`I2A_ASSERT_IMPLIES(a_bcd_top, clk, arst_n, state_q == ST_CONV, top_digit <= DEC_MAX)
	// A last-character transfer out of EMIT returns the block to idle.
	`I2A_ASSERT_NEXT(a_last_idle, clk, arst_n, emit_go && emit_last, s_tready && m_tvalid && m_tlast)

endmodule

@@ src/i2a_cell.sv @@
// ----------------------------------------------------------------------------
// Integer to ASCII formatter digit cell
// Holds one digit. Converts binary to BCD two bits a cycle (shift and add
// three), and shifts whole digits toward the most significant end for output.
// ----------------------------------------------------------------------------
module i2a_cell
	import i2a_pkg::*;
(
	input  logic               clk,
	input  cell_ctrl_t         ctrl,
	input  logic [DIGIT_W-1:0] load_digit,
	input  logic [1:0]         in_bits,
	input  logic [DIGIT_W-1:0] in_digit,
	output logic [DIGIT_W-1:0] digit,
	output logic [1:0]         out_bits
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj1;
	logic [DIGIT_W-1:0] step1;
	logic [DIGIT_W-1:0] adj2;
	logic [DIGIT_W-1:0] step2;

	// Two shift-and-add-three steps; each step takes one bit from the neighbor.
	always_comb begin
		adj1  = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
		step1 = {adj1[DIGIT_W-2:0], in_bits[1]};
		adj2  = (step1 >= 4'd5) ? step1 + 4'd3 : step1;
		step2 = {adj2[DIGIT_W-2:0], in_bits[0]};
	end

	assign out_bits = {adj1[DIGIT_W-1], adj2[DIGIT_W-1]};
	assign digit    = digit_q;

	// Digit register.
	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			CELL_HOLD:   digit_q <= digit_q;
			CELL_LOAD:   digit_q <= load_digit;
			CELL_DABBLE: digit_q <= step2;
			CELL_SHIFT:  digit_q <= in_digit;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule
